### hdl/pfx_eval_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// No dependencies; imported by postfix_expression_evaluator.
package pfx_eval_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_RIGHT,
      ST_RD_LEFT,
      ST_EXEC,
      ST_DIV,
      ST_DIV_END,
      ST_FIN_RD,
      ST_FIN_OUT
   } state_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_MOD
   } op_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned STEP_W   = 5;
   localparam logic [STEP_W-1:0] STEP_LAST = 5'd31;

endpackage

### hdl/postfix_expression_evaluator.sv
// Postfix evaluator: digits are pushed from idle; + - * read both operands and
// execute; / and % then run a radix-2 restoring divider, one quotient bit per
// cycle over 32 steps. A token marked last then reads the stack top before the
// result beat. One token in flight at a time; req_stall is high while a token
// is being worked. Synchronous active-high reset clears the sequencer, stack
// count, error latch and result valid; the stack memory itself is not cleared.
module postfix_expression_evaluator
   import pfx_eval_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_token,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [1:0]         rsp_status
);

   localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);

   // stack storage
   logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [1:0]        err_ff, err_in;
   op_type            op_ff, op_in;
   logic              last_ff, last_in;
   logic [WORD_W-1:0] right_ff, right_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] div_ff, div_in;
   logic              neg_q_ff, neg_q_in;
   logic              neg_r_ff, neg_r_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic              in_acc;
   logic              out_free;
   logic              is_digit;
   logic              is_op;
   op_type            tok_op;
   logic              few_operands;
   logic              is_divide;
   logic [ADDR_W-1:0] top_addr;
   logic [ADDR_W-1:0] next_addr;
   logic [WORD_W-1:0] left_val;
   logic [WORD_W-1:0] left_mag;
   logic [WORD_W-1:0] right_mag;
   logic [WORD_W-1:0] prod;
   logic [WORD_W-1:0] arith_res;
   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   diff;
   logic              fits;
   logic [WORD_W-1:0] div_res;

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   assign in_acc   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // token decode
   always_comb begin
      is_digit = (req_token inside {[CHAR_ZERO:CHAR_NINE]});
      is_op    = 1'b1;
      tok_op   = OP_ADD;
      case (req_token)
         CHAR_PLUS:    tok_op = OP_ADD;
         CHAR_MINUS:   tok_op = OP_SUB;
         CHAR_STAR:    tok_op = OP_MUL;
         CHAR_SLASH:   tok_op = OP_DIV;
         CHAR_PERCENT: tok_op = OP_MOD;
         default:      is_op  = 1'b0;
      endcase
   end

   assign few_operands = (count_ff < CNT_W'(2));
   assign top_addr     = ADDR_W'(count_ff - CNT_W'(1));
   assign next_addr    = ADDR_W'(count_ff - CNT_W'(2));
   assign is_divide    = (op_ff == OP_DIV) || (op_ff == OP_MOD);

   // shared datapath: operands come from the stack read register
   assign left_val  = rd_data_ff;
   assign left_mag  = left_val[WORD_W-1] ? (WORD_W'(0) - left_val) : left_val;
   assign right_mag = right_ff[WORD_W-1] ? (WORD_W'(0) - right_ff) : right_ff;
   assign prod      = WORD_W'(left_val * right_ff);

   always_comb begin
      case (op_ff)
         OP_ADD:  arith_res = left_val + right_ff;
         OP_SUB:  arith_res = left_val - right_ff;
         default: arith_res = prod;
      endcase
   end

   // one restoring-division step
   assign shifted = {rem_ff, quo_ff[WORD_W-1]};
   assign fits    = (shifted >= {1'b0, div_ff});
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      if (op_ff == OP_DIV) begin
         div_res = neg_q_ff ? (WORD_W'(0) - quo_ff) : quo_ff;
      end else begin
         div_res = neg_r_ff ? (WORD_W'(0) - rem_ff) : rem_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_acc) begin
               if ((err_ff == STATUS_OK) && is_op && !few_operands) begin
                  state_in = ST_RD_RIGHT;
               end else if (req_last) begin
                  state_in = ST_FIN_RD;
               end
            end
         end
         ST_RD_RIGHT: state_in = ST_RD_LEFT;
         ST_RD_LEFT:  state_in = ST_EXEC;
         ST_EXEC: begin
            if (is_divide && (right_ff != '0)) begin
               state_in = ST_DIV;
            end else begin
               state_in = last_ff ? ST_FIN_RD : ST_IDLE;
            end
         end
         ST_DIV: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: state_in = last_ff ? ST_FIN_RD : ST_IDLE;
         ST_FIN_RD:  state_in = ST_FIN_OUT;
         ST_FIN_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and control outputs
   always_comb begin
      count_in      = count_ff;
      err_in        = err_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      right_in      = right_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      neg_q_in      = neg_q_ff;
      neg_r_in      = neg_r_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = top_addr;
      wr_en         = 1'b0;
      wr_addr       = next_addr;
      wr_data       = arith_res;
      case (state_ff)
         ST_IDLE: begin
            if (in_acc) begin
               op_in   = tok_op;
               last_in = req_last;
               if (err_ff == STATUS_OK) begin
                  if (is_digit) begin
                     if (count_ff == CNT_W'(STACK_DEPTH)) begin
                        err_in = STATUS_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[ADDR_W-1:0];
                        wr_data  = WORD_W'(req_token - CHAR_ZERO);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end else if (is_op && few_operands) begin
                     err_in = STATUS_UNDERFLOW;
                  end
               end
            end
         end
         ST_RD_LEFT: begin
            rd_addr  = next_addr;
            right_in = rd_data_ff;
         end
         ST_EXEC: begin
            if (is_divide) begin
               if (right_ff == '0) begin
                  err_in = STATUS_DIV_ZERO;
               end else begin
                  quo_in   = left_mag;
                  rem_in   = '0;
                  div_in   = right_mag;
                  neg_q_in = left_val[WORD_W-1] ^ right_ff[WORD_W-1];
                  neg_r_in = left_val[WORD_W-1];
                  step_in  = '0;
               end
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         ST_DIV: begin
            quo_in  = {quo_ff[WORD_W-2:0], fits};
            rem_in  = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            step_in = step_ff + STEP_W'(1);
         end
         ST_DIV_END: begin
            wr_en    = 1'b1;
            wr_data  = div_res;
            count_in = count_ff - CNT_W'(1);
         end
         ST_FIN_OUT: begin
            // hold the top read until the result register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff != STATUS_OK) begin
                  rsp_value_in  = '0;
                  rsp_status_in = err_ff;
               end else if (count_ff == '0) begin
                  rsp_value_in  = '0;
                  rsp_status_in = STATUS_UNDERFLOW;
               end else begin
                  rsp_value_in  = rd_data_ff;
                  rsp_status_in = STATUS_OK;
               end
               count_in = '0;
               err_in   = STATUS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      last_ff       <= last_in;
      right_ff      <= right_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      neg_q_ff      <= neg_q_in;
      neg_r_ff      <= neg_r_in;
      step_ff       <= step_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
